@@ src/sed_pkg.sv @@
// Shared types, character constants and helpers for the string escape decoder.
package sed_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_QUEST = 8'h3f;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0b;

  typedef enum logic [2:0] {
    MODE_PLAIN = 3'd0,
    MODE_ESC   = 3'd1,
    MODE_HEX1  = 3'd2,
    MODE_HEX2  = 3'd3,
    MODE_OCT1  = 3'd4,
    MODE_OCT2  = 3'd5
  } esc_mode_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_final;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       bad_escape;
    logic       string_done;
    logic       run_last;
  } out_item_t;

  // One decode step: up to two results plus the next escape state.
  typedef struct packed {
    logic [1:0] count;
    out_item_t  res0;
    out_item_t  res1;
    esc_mode_t  mode;
    logic [7:0] value;
  } dec_step_t;

  // {valid, digit value}
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

  // {hit, control code} for the single-letter escapes
  function automatic logic [8:0] letter_escape(input logic [7:0] b);
    logic [8:0] r;
    r = 9'd0;
    case (b)
      8'h61:   r = {1'b1, CH_BEL};
      8'h62:   r = {1'b1, CH_BS};
      8'h66:   r = {1'b1, CH_FF};
      8'h6e:   r = {1'b1, CH_LF};
      8'h72:   r = {1'b1, CH_CR};
      8'h74:   r = {1'b1, CH_TAB};
      8'h76:   r = {1'b1, CH_VT};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

@@ src/string_escape_decoder.sv @@
// Top level of the string escape decoder: input register, escape state, result queue.
// A byte is held in the input register after its in_ transfer and is decoded once
//   the queue has room for two results; its results are registered in the queue for out_.
// Throughput: one byte per cycle while bytes give at most one result and out_ready keeps
//   the queue from filling; two results of one byte leave the single-result port in turn.
// Reset (rst_n low, synchronous): plain-text state, value zero, input register and queue empty.
module string_escape_decoder
  import sed_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // input register stage
  logic      in_valid_r, in_valid_nxt;
  in_item_t  in_data_r;

  // escape state carried between bytes
  esc_mode_t  mode_r, mode_nxt;
  logic [7:0] value_r, value_nxt;

  dec_step_t  step;
  logic       room2;
  logic       dec_fire;
  logic [1:0] push_count;

  // Decode the held byte once the queue can take both possible results.
  assign dec_fire   = in_valid_r && room2;
  assign in_ready   = !in_valid_r || dec_fire;
  assign push_count = dec_fire ? step.count : 2'd0;

  sed_decode u_decode (
    .item  (in_data_r),
    .mode  (mode_r),
    .value (value_r),
    .step  (step)
  );

  sed_result_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_count (push_count),
    .push0      (step.res0),
    .push1      (step.res1),
    .room2      (room2),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    mode_nxt     = mode_r;
    value_nxt    = value_r;
    if (dec_fire) begin
      in_valid_nxt = 1'b0;
      mode_nxt     = step.mode;
      value_nxt    = step.value;
    end
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      mode_r     <= MODE_PLAIN;
      value_r    <= 8'd0;
    end else begin
      in_valid_r <= in_valid_nxt;
      mode_r     <= mode_nxt;
      value_r    <= value_nxt;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

endmodule

@@ src/sed_decode.sv @@
// Combinational decode of one byte against the current escape state.
module sed_decode
  import sed_pkg::*;
(
  input  in_item_t   item,
  input  esc_mode_t  mode,
  input  logic [7:0] value,
  output dec_step_t  step
);

  logic [7:0] b;
  logic       fin;
  logic       is_bsl;
  logic       p_emit;
  logic       p_esc;
  out_item_t  p_item;
  logic [4:0] hd;
  logic [8:0] le;
  logic [7:0] oct_v;
  logic       is_oct;

  assign b      = item.in_byte;
  assign fin    = item.is_final;
  assign is_bsl = (b == CH_BSL);
  // plain-text handling of a byte
  assign p_emit = !is_bsl || fin;
  assign p_esc  = is_bsl && !fin;
  assign p_item = '{out_byte: b, bad_escape: is_bsl, string_done: 1'b0, run_last: 1'b0};
  assign hd     = hex_digit(b);
  assign le     = letter_escape(b);
  assign is_oct = (b[7:3] == 5'b00110);
  assign oct_v  = {value[4:0], b[2:0]};

  always_comb begin
    logic       e0;
    logic       e1;
    out_item_t  r0;
    out_item_t  r1;
    esc_mode_t  m;
    logic [7:0] v;
    e0 = 1'b0;
    e1 = 1'b0;
    r0 = '0;
    r1 = '0;
    m  = mode;
    v  = value;
    unique case (mode)
      MODE_ESC: begin
        m = MODE_PLAIN;
        if (le[8]) begin
          e0 = 1'b1;
          r0.out_byte = le[7:0];
        end else if (b == CH_X) begin
          if (fin) begin
            e0 = 1'b1;
            r0.out_byte = CH_QUEST;
            r0.bad_escape = 1'b1;
          end else begin
            m = MODE_HEX1;
          end
        end else if (b[7:2] == 6'b001100) begin
          v = {6'd0, b[1:0]};
          if (fin) begin
            e0 = 1'b1;
            r0.out_byte = v;
          end else begin
            m = MODE_OCT1;
          end
        end else begin
          e0 = 1'b1;
          r0.out_byte = b;
        end
      end
      MODE_HEX1: begin
        if (hd[4]) begin
          v = {hd[3:0], 4'd0};
          if (fin) begin
            e0 = 1'b1;
            r0.out_byte = CH_QUEST;
            r0.bad_escape = 1'b1;
          end else begin
            m = MODE_HEX2;
          end
        end else begin
          m  = p_esc ? MODE_ESC : MODE_PLAIN;
          e0 = 1'b1;
          r0.out_byte = CH_QUEST;
          r0.bad_escape = 1'b1;
          e1 = p_emit;
          r1 = p_item;
        end
      end
      MODE_HEX2: begin
        e0 = 1'b1;
        if (hd[4]) begin
          m = MODE_PLAIN;
          r0.out_byte = value | {4'd0, hd[3:0]};
        end else begin
          m  = p_esc ? MODE_ESC : MODE_PLAIN;
          r0.out_byte = CH_QUEST;
          r0.bad_escape = 1'b1;
          e1 = p_emit;
          r1 = p_item;
        end
      end
      MODE_OCT1, MODE_OCT2: begin
        if (is_oct) begin
          v = oct_v;
          if (mode == MODE_OCT2 || fin) begin
            m  = MODE_PLAIN;
            e0 = 1'b1;
            r0.out_byte = oct_v;
          end else begin
            m = MODE_OCT2;
          end
        end else begin
          m  = p_esc ? MODE_ESC : MODE_PLAIN;
          e0 = 1'b1;
          r0.out_byte = value;
          e1 = p_emit;
          r1 = p_item;
        end
      end
      default: begin
        m  = p_esc ? MODE_ESC : MODE_PLAIN;
        e0 = p_emit;
        r0 = p_item;
      end
    endcase

    // tag the last result of this byte
    if (e1) begin
      r1.run_last    = 1'b1;
      r1.string_done = fin;
    end else if (e0) begin
      r0.run_last    = 1'b1;
      r0.string_done = fin;
    end
    if (fin) begin
      m = MODE_PLAIN;
      v = 8'd0;
    end

    step.count = {e0 & e1, e0 ^ (e0 & e1)};
    step.res0  = r0;
    step.res1  = r1;
    step.mode  = m;
    step.value = v;
  end

endmodule

@@ src/sed_result_queue.sv @@
// Small result queue: takes up to two results per cycle, gives one per cycle while out_ready is high.
module sed_result_queue
  import sed_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_count,
  input  out_item_t  push0,
  input  out_item_t  push1,
  output logic       room2,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  out_item_t          mem_r [QueueDepth];
  logic [PtrW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]    count_r, count_nxt;
  logic               pop;
  logic [PtrW-1:0]    wr_ptr_p1;

  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign room2     = (count_r <= CntW'(QueueDepth - 2));
  assign wr_ptr_p1 = wr_ptr_r + PtrW'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PtrW'(push_count);
    rd_ptr_nxt = rd_ptr_r + PtrW'(pop);
    count_nxt  = count_r + CntW'(push_count) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem_r[wr_ptr_r] <= push0;
    end
    if (push_count == 2'd2) begin
      mem_r[wr_ptr_p1] <= push1;
    end
  end

endmodule
